[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with rst_n low as the disable.
`define SCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/scd_pkg.sv]
`default_nettype none
package scd_pkg;

  localparam int SERIES_MAX = 1024;
  localparam int IDX_W      = $clog2(SERIES_MAX);
  localparam int CNT_W      = $clog2(SERIES_MAX + 1);

  localparam int SUM_W = 26;
  localparam int SQ_W  = 42;
  localparam int XS_W  = 48;
  localparam int HIT_W = 24;
  localparam int VS_W  = 48;
  localparam int D2_W  = 18;
  localparam int THR_W = 17;

  localparam logic [2:0] REG_THRESHOLD     = 3'd0;
  localparam logic [2:0] REG_SIGN_MODE     = 3'd1;
  localparam logic [2:0] REG_REGION_MODE   = 3'd2;
  localparam logic [2:0] REG_SPHERE_RADIUS = 3'd3;
  localparam logic [2:0] REG_SERIES_LENGTH = 3'd4;
  localparam logic [2:0] REG_OUTPUT_MODE   = 3'd5;

  localparam logic [1:0] SM_ABS  = 2'd0;
  localparam logic [1:0] SM_POS  = 2'd1;
  localparam logic [1:0] SM_NEG  = 2'd2;

  localparam logic [1:0] RM_OUTSIDE = 2'd1;
  localparam logic [1:0] RM_INSIDE  = 2'd2;

  localparam logic [1:0] OM_MEAN_R    = 2'd1;
  localparam logic [1:0] OM_MEAN_DIST = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [1:0]       sign_mode;
    logic [1:0]       region_mode;
    logic [7:0]       sphere_radius;
    logic [1:0]       output_mode;
  } cfg_t;

  typedef struct packed {
    logic            cnt_ok;
    logic            incl;
    logic            lastvox;
    logic [D2_W-1:0] d2;
  } eval_req_t;

  typedef struct packed {
    logic             valid;
    logic [HIT_W-1:0] value;
    logic [HIT_W-1:0] hits;
  } res_t;

endpackage
`default_nettype wire

[src/scd_ram.sv]
`default_nettype none
module scd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/scd_eval.sv]
`default_nettype none
module scd_eval
  import scd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire eval_req_t               req,
  input  wire cfg_t                    cfg,
  input  wire logic [CNT_W-1:0]        n,
  input  wire logic signed [SUM_W-1:0] cand_sum,
  input  wire logic [SQ_W-1:0]         cand_sq,
  input  wire logic signed [XS_W-1:0]  cross_sum,
  input  wire logic signed [SUM_W-1:0] seed_sum,
  input  wire logic [SQ_W-1:0]         seed_sq,
  input  wire logic                    hit_clr,
  input  wire logic                    out_free,
  output logic                         busy,
  output res_t                         res
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_M1   = 5'd1;
  localparam logic [4:0] ST_M2   = 5'd2;
  localparam logic [4:0] ST_M3   = 5'd3;
  localparam logic [4:0] ST_M4   = 5'd4;
  localparam logic [4:0] ST_M5   = 5'd5;
  localparam logic [4:0] ST_M6   = 5'd6;
  localparam logic [4:0] ST_CHK  = 5'd7;
  localparam logic [4:0] ST_SQA  = 5'd8;
  localparam logic [4:0] ST_SQB  = 5'd9;
  localparam logic [4:0] ST_DEN  = 5'd10;
  localparam logic [4:0] ST_DIV0 = 5'd11;
  localparam logic [4:0] ST_DIV  = 5'd12;
  localparam logic [4:0] ST_DEC  = 5'd13;
  localparam logic [4:0] ST_SQD  = 5'd14;
  localparam logic [4:0] ST_FIN  = 5'd15;
  localparam logic [4:0] ST_MEAN = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  localparam logic [63:0]      SQ_TOP   = 64'h4000_0000_0000_0000;
  localparam logic [HIT_W-1:0] HIT_MAX  = '1;
  localparam logic [VS_W-1:0]  VSUM_MAX = '1;
  localparam logic [16:0]      MAG_ONE  = 17'h10000;

  logic [4:0]         st_r, st_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] sxx_r, sxx_nxt, syy_r, syy_nxt, sxy_r, sxy_nxt;
  logic [63:0]        sqv_r, sqv_nxt, sqq_r, sqq_nxt, sqb_r, sqb_nxt;
  logic [31:0]        a_r, a_nxt, b_r, b_nxt;
  logic [63:0]        den_r, den_nxt, num_r, num_nxt, rem_r, rem_nxt;
  logic [VS_W-1:0]    dv_r, dv_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [16:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [HIT_W-1:0]   hits_r, hits_nxt;
  logic [VS_W-1:0]    vsum_r, vsum_nxt;

  logic signed [XS_W-1:0]        op_w;
  logic signed [CNT_W+XS_W:0]    p_nc;
  logic signed [SUM_W-1:0]       op_a, op_b;
  logic signed [2*SUM_W-1:0]     p_ss;
  logic [63:0]        sq_t, sqv_n, sqq_n, sxy_abs, div_t;
  logic               sq_ge, div_ge, mean_ge, pass, do_add;
  logic [HIT_W:0]     mean_t;
  logic [HIT_W-1:0]   add_val, res_val;
  logic [VS_W:0]      vs_sum;
  logic [15:0]        rad2;
  logic               mean_mode;
  res_t               res_c;

  always_comb begin
    op_w = cross_sum;
    op_a = cand_sum;
    op_b = cand_sum;
    case (st_r)
      ST_M1:   op_w = $signed({{(XS_W-SQ_W){1'b0}}, cand_sq});
      ST_M3:   op_w = $signed({{(XS_W-SQ_W){1'b0}}, seed_sq});
      default: op_w = cross_sum;
    endcase
    case (st_r)
      ST_M4: begin
        op_a = seed_sum;
        op_b = seed_sum;
      end
      ST_M6: begin
        op_a = cand_sum;
        op_b = seed_sum;
      end
      default: begin
        op_a = cand_sum;
        op_b = cand_sum;
      end
    endcase
  end

  assign p_nc = $signed({1'b0, n}) * op_w;
  assign p_ss = op_a * op_b;

  assign sq_t  = sqq_r + sqb_r;
  assign sq_ge = sqv_r >= sq_t;
  assign sqv_n = sq_ge ? sqv_r - sq_t : sqv_r;
  assign sqq_n = sq_ge ? (sqq_r >> 1) + sqb_r : sqq_r >> 1;

  assign sxy_abs = sxy_r[63] ? 64'(-sxy_r) : 64'(sxy_r);
  assign div_t   = {rem_r[62:0], 1'b0};
  assign div_ge  = div_t >= den_r;
  assign mean_t  = {rem_r[HIT_W-1:0], dv_r[VS_W-1]};
  assign mean_ge = mean_t >= {1'b0, hits_r};
  assign rad2    = cfg.sphere_radius * cfg.sphere_radius;
  assign vs_sum  = {1'b0, vsum_r} + {{(VS_W-HIT_W+1){1'b0}}, add_val};
  assign mean_mode = (cfg.output_mode == OM_MEAN_R) || (cfg.output_mode == OM_MEAN_DIST);

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    sxx_nxt  = sxx_r;
    syy_nxt  = syy_r;
    sxy_nxt  = sxy_r;
    sqv_nxt  = sqv_r;
    sqq_nxt  = sqq_r;
    sqb_nxt  = sqb_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    hits_nxt = hits_r;
    vsum_nxt = vsum_r;
    pass     = 1'b0;
    do_add   = 1'b0;
    add_val  = '0;
    res_val  = '0;
    res_c    = '0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt = ST_M1;
        end
      end
      ST_M1, ST_M3, ST_M5: begin
        acc_nxt = 64'(p_nc);
        st_nxt  = st_r + 5'd1;
      end
      ST_M2: begin
        sxx_nxt = acc_r - 64'(p_ss);
        st_nxt  = ST_M3;
      end
      ST_M4: begin
        syy_nxt = acc_r - 64'(p_ss);
        st_nxt  = ST_M5;
      end
      ST_M6: begin
        sxy_nxt = acc_r - 64'(p_ss);
        st_nxt  = ST_CHK;
      end
      ST_CHK: begin
        if (!req.cnt_ok || !req.incl || req.d2 == '0 ||
            sxx_r <= 64'sd0 || syy_r <= 64'sd0) begin
          st_nxt = ST_FIN;
        end else begin
          sqv_nxt = {sxx_r[55:0], 8'd0};
          sqq_nxt = '0;
          sqb_nxt = SQ_TOP;
          cnt_nxt = 6'd31;
          st_nxt  = ST_SQA;
        end
      end
      ST_SQA, ST_SQB, ST_SQD: begin
        sqv_nxt = sqv_n;
        sqq_nxt = sqq_n;
        sqb_nxt = sqb_r >> 2;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          case (st_r)
            ST_SQA: begin
              a_nxt   = sqq_n[31:0];
              sqv_nxt = {syy_r[55:0], 8'd0};
              sqq_nxt = '0;
              sqb_nxt = SQ_TOP;
              cnt_nxt = 6'd31;
              st_nxt  = ST_SQB;
            end
            ST_SQB: begin
              b_nxt  = sqq_n[31:0];
              st_nxt = ST_DEN;
            end
            default: begin
              do_add  = 1'b1;
              add_val = sqq_n[HIT_W-1:0];
              st_nxt  = ST_FIN;
            end
          endcase
        end
      end
      ST_DEN: begin
        den_nxt = a_r * b_r;
        num_nxt = {sxy_abs[55:0], 8'd0};
        neg_nxt = sxy_r[63];
        st_nxt  = ST_DIV0;
      end
      ST_DIV0: begin
        if (den_r == '0) begin
          st_nxt = ST_FIN;
        end else if (num_r >= den_r) begin
          mag_nxt = MAG_ONE;
          st_nxt  = ST_DEC;
        end else begin
          rem_nxt = num_r;
          mag_nxt = '0;
          cnt_nxt = 6'd15;
          st_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_t - den_r : div_t;
        mag_nxt = {mag_r[15:0], div_ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          st_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        st_nxt = ST_FIN;
        case (cfg.output_mode)
          OM_MEAN_R: begin
            if (!neg_r && mag_r != '0) begin
              do_add  = 1'b1;
              add_val = HIT_W'(mag_r);
            end
          end
          OM_MEAN_DIST: begin
            pass = neg_r ? (mag_r == '0 && cfg.threshold == '0) : (mag_r >= cfg.threshold);
            if (pass) begin
              sqv_nxt = {{(48-D2_W){1'b0}}, req.d2, 16'd0};
              sqq_nxt = '0;
              sqb_nxt = SQ_TOP;
              cnt_nxt = 6'd31;
              st_nxt  = ST_SQD;
            end
          end
          default: begin
            case (cfg.sign_mode)
              SM_ABS:  pass = mag_r > cfg.threshold;
              SM_POS:  pass = !neg_r && mag_r > cfg.threshold;
              SM_NEG:  pass = neg_r && mag_r > cfg.threshold;
              default: pass = 1'b0;
            endcase
            if (cfg.region_mode == RM_OUTSIDE && req.d2 <= D2_W'(rad2)) begin
              pass = 1'b0;
            end
            if (cfg.region_mode == RM_INSIDE && req.d2 > D2_W'(rad2)) begin
              pass = 1'b0;
            end
            do_add = pass;
          end
        endcase
      end
      ST_FIN: begin
        if (!req.lastvox) begin
          st_nxt = ST_IDLE;
        end else if (mean_mode && hits_r != '0) begin
          rem_nxt = '0;
          dv_nxt  = vsum_r;
          cnt_nxt = 6'(VS_W - 1);
          st_nxt  = ST_MEAN;
        end else begin
          dv_nxt = mean_mode ? '0 : VS_W'(hits_r);
          st_nxt = ST_OUT;
        end
      end
      ST_MEAN: begin
        rem_nxt = 64'(mean_ge ? mean_t - {1'b0, hits_r} : mean_t);
        dv_nxt  = {dv_r[VS_W-2:0], mean_ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        res_val = (dv_r[VS_W-1:HIT_W] != '0) ? HIT_MAX : dv_r[HIT_W-1:0];
        if (out_free) begin
          res_c.valid = 1'b1;
          res_c.value = res_val;
          res_c.hits  = hits_r;
          hits_nxt    = '0;
          vsum_nxt    = '0;
          st_nxt      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (do_add) begin
      if (hits_r != HIT_MAX) begin
        hits_nxt = hits_r + HIT_W'(1);
      end
      vsum_nxt = vs_sum[VS_W] ? VSUM_MAX : vs_sum[VS_W-1:0];
    end
    if (hit_clr) begin
      hits_nxt = '0;
      vsum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      hits_r <= '0;
      vsum_r <= '0;
    end else begin
      st_r   <= st_nxt;
      hits_r <= hits_nxt;
      vsum_r <= vsum_nxt;
    end
    acc_r <= acc_nxt;
    sxx_r <= sxx_nxt;
    syy_r <= syy_nxt;
    sxy_r <= sxy_nxt;
    sqv_r <= sqv_nxt;
    sqq_r <= sqq_nxt;
    sqb_r <= sqb_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = st_r != ST_IDLE;
  assign res  = res_c;

endmodule
`default_nettype wire

[src/seed_correlation_degree_engine_core.sv]
`default_nettype none
`include "assert_macros.svh"
// Seed correlation degree engine. Seed and candidate samples stream in at one
// transfer per cycle; the seed series is kept in a 1024-entry RAM and each
// candidate sample reads its seed partner from it. At a candidate's last sample
// the input stalls while a shared sequencer forms the Pearson r: an excluded
// candidate goes straight to the finish, a full one takes two 32-step square
// roots and a 16-step divide, a summed distance adds a 32-step square root, and
// at the last candidate the mean output modes add a mean divide. The result waits in an
// output register and does not hold up the next samples; only a second result
// that finds that register still full stalls the sequencer until it drains.
module seed_correlation_degree_engine_core
  import scd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // sample_value, x_coord, y_coord, z_coord
  input  wire logic [2:0]  in_tuser,  // req_type, voxel_included, last_voxel
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // result_value, hits
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);

  cfg_t               cfg_r;
  logic [10:0]        series_length_r;
  logic [CNT_W-1:0]   n;

  logic [CNT_W-1:0]   sidx_r, sidx_nxt, seed_cnt_r, seed_cnt_nxt;
  logic               cur_type_r;
  logic signed [SUM_W-1:0] seed_sum_r, seed_sum_nxt, cand_sum_r, cand_sum_nxt;
  logic [SQ_W-1:0]    seed_sq_r, seed_sq_nxt, cand_sq_r, cand_sq_nxt;
  logic signed [XS_W-1:0] cross_r, cross_nxt;
  logic [7:0]         sx_r, sy_r, sz_r;

  logic               s2_valid_r, s2_last_r, s2_start_r, s2_add_r, s2_yv_r, pend_r;
  logic signed [15:0] s2_x_r;
  eval_req_t          req_r, req_nxt;

  logic               acc, typ, start, inr;
  logic signed [15:0] xin, yv;
  logic [7:0]         cx, cy, cz;
  logic [CNT_W-1:0]   idx, idx_end;
  logic signed [8:0]  dx, dy, dz;
  logic [D2_W-1:0]    d2;
  logic signed [31:0] xsq, s2_sq, s2_xy;
  logic               hit_clr, eval_busy, out_free, out_valid_r;
  logic [15:0]        ram_rdata;
  logic [47:0]        out_data_r;
  res_t               res;

  assign xin = $signed(in_tdata[15:0]);
  assign cx  = in_tdata[23:16];
  assign cy  = in_tdata[31:24];
  assign cz  = in_tdata[39:32];
  assign typ = in_tuser[0];

  always_comb begin
    if (series_length_r < 11'd2) begin
      n = CNT_W'(2);
    end else if (CNT_W'(series_length_r) > CNT_W'(SERIES_MAX) || series_length_r > 11'(SERIES_MAX)) begin
      n = CNT_W'(SERIES_MAX);
    end else begin
      n = CNT_W'(series_length_r);
    end
  end

  assign in_tready = !eval_busy && !s2_last_r && !pend_r;
  assign acc       = in_tvalid && in_tready;
  assign start     = (sidx_r == '0) || (typ != cur_type_r);
  assign idx       = start ? '0 : sidx_r;
  assign inr       = idx < n;
  assign idx_end   = inr ? idx + CNT_W'(1) : idx;
  assign xsq       = xin * xin;
  assign dx = $signed({1'b0, cx}) - $signed({1'b0, sx_r});
  assign dy = $signed({1'b0, cy}) - $signed({1'b0, sy_r});
  assign dz = $signed({1'b0, cz}) - $signed({1'b0, sz_r});
  assign d2 = D2_W'(dx * dx) + D2_W'(dy * dy) + D2_W'(dz * dz);
  assign hit_clr = acc && !typ && start;

  always_comb begin
    sidx_nxt     = sidx_r;
    seed_cnt_nxt = seed_cnt_r;
    seed_sum_nxt = seed_sum_r;
    seed_sq_nxt  = seed_sq_r;
    req_nxt      = req_r;
    if (acc) begin
      sidx_nxt = in_tlast ? '0 : idx_end;
      if (!typ) begin
        if (start) begin
          seed_cnt_nxt = '0;
          seed_sum_nxt = '0;
          seed_sq_nxt  = '0;
        end
        if (inr) begin
          seed_cnt_nxt = idx_end;
          seed_sum_nxt = seed_sum_nxt + SUM_W'(xin);
          seed_sq_nxt  = seed_sq_nxt + SQ_W'(unsigned'(xsq));
        end
      end else if (in_tlast) begin
        req_nxt.cnt_ok  = (idx_end == n) && (seed_cnt_r == n);
        req_nxt.incl    = in_tuser[1];
        req_nxt.lastvox = in_tuser[2];
        req_nxt.d2      = d2;
      end
    end
  end

  scd_ram #(.WIDTH(16), .DEPTH(SERIES_MAX)) u_seed_ram (
    .clk   (clk),
    .we    (acc && !typ && inr),
    .waddr (idx[IDX_W-1:0]),
    .wdata (in_tdata[15:0]),
    .raddr (idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign yv    = s2_yv_r ? $signed(ram_rdata) : 16'sd0;
  assign s2_sq = s2_x_r * s2_x_r;
  assign s2_xy = s2_x_r * yv;

  always_comb begin
    cand_sum_nxt = cand_sum_r;
    cand_sq_nxt  = cand_sq_r;
    cross_nxt    = cross_r;
    if (s2_valid_r) begin
      if (s2_start_r) begin
        cand_sum_nxt = '0;
        cand_sq_nxt  = '0;
        cross_nxt    = '0;
      end
      if (s2_add_r) begin
        cand_sum_nxt = cand_sum_nxt + SUM_W'(s2_x_r);
        cand_sq_nxt  = cand_sq_nxt + SQ_W'(unsigned'(s2_sq));
        cross_nxt    = cross_nxt + XS_W'(s2_xy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= THR_W'(16384);
      cfg_r.sign_mode     <= '0;
      cfg_r.region_mode   <= '0;
      cfg_r.sphere_radius <= 8'd3;
      cfg_r.output_mode   <= '0;
      series_length_r     <= 11'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:     cfg_r.threshold     <= cfg_wdata;
        REG_SIGN_MODE:     cfg_r.sign_mode     <= cfg_wdata[1:0];
        REG_REGION_MODE:   cfg_r.region_mode   <= cfg_wdata[1:0];
        REG_SPHERE_RADIUS: cfg_r.sphere_radius <= cfg_wdata[7:0];
        REG_SERIES_LENGTH: series_length_r     <= cfg_wdata[10:0];
        REG_OUTPUT_MODE:   cfg_r.output_mode   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r      <= '0;
      seed_cnt_r  <= '0;
      cur_type_r  <= 1'b0;
      seed_sum_r  <= '0;
      seed_sq_r   <= '0;
      cand_sum_r  <= '0;
      cand_sq_r   <= '0;
      cross_r     <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
      s2_valid_r  <= 1'b0;
      s2_last_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sidx_r     <= sidx_nxt;
      seed_cnt_r <= seed_cnt_nxt;
      seed_sum_r <= seed_sum_nxt;
      seed_sq_r  <= seed_sq_nxt;
      cand_sum_r <= cand_sum_nxt;
      cand_sq_r  <= cand_sq_nxt;
      cross_r    <= cross_nxt;
      if (acc) begin
        cur_type_r <= typ;
      end
      if (acc && !typ) begin
        sx_r <= cx;
        sy_r <= cy;
        sz_r <= cz;
      end
      s2_valid_r <= acc && typ;
      s2_last_r  <= acc && typ && in_tlast;
      pend_r     <= s2_last_r;
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    s2_start_r <= start;
    s2_add_r   <= inr;
    s2_yv_r    <= idx < seed_cnt_r;
    s2_x_r     <= xin;
    req_r      <= req_nxt;
    if (res.valid) begin
      out_data_r <= {res.hits, res.value};
    end
  end

  assign out_free = !out_valid_r || out_tready;

  scd_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pend_r),
    .req       (req_r),
    .cfg       (cfg_r),
    .n         (n),
    .cand_sum  (cand_sum_r),
    .cand_sq   (cand_sq_r),
    .cross_sum (cross_r),
    .seed_sum  (seed_sum_r),
    .seed_sq   (seed_sq_r),
    .hit_clr   (hit_clr),
    .out_free  (out_free),
    .busy      (eval_busy),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SCD_ASSERT_IMP(a_start_when_idle, pend_r, !eval_busy)
  `SCD_ASSERT_IMP(a_result_has_slot, res.valid, out_free)
  `SCD_ASSERT_NXT(a_stall_after_last, s2_last_r, !in_tready)
  `SCD_ASSERT_IMP(a_index_bound, 1'b1, sidx_r <= CNT_W'(SERIES_MAX))

endmodule
`default_nettype wire
